[hdl/pdfifo_pkg.sv]
// pdfifo_pkg: shared types, codes and reset constants of the paced delay queue.
// No dependencies; used by paced_delay_fifo_core.
package pdfifo_pkg;

   localparam int QUEUE_DEPTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;

   localparam int TAG_W   = 16;
   localparam int LEN_W   = 16;
   localparam int TIME_W  = 32;
   localparam int RATE_W  = 24;
   localparam int WAIT_W  = 16;
   localparam int KIND_W  = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 32;
   localparam int Q8_SHIFT  = 8;   // rates carry 8 fraction bits

   // input operation codes
   localparam logic OP_ARRIVAL = 1'b0;
   localparam logic OP_TICK    = 1'b1;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_ACCEPTED = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DROPPED  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RELEASED = 2'd2;
   localparam logic [KIND_W-1:0] KIND_STATUS   = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WARMUP_RATE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAIN_RATE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WARMUP_MS   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BUDGET_MS   = 2'd3;

   // register reset values
   localparam logic [RATE_W-1:0] WARMUP_RATE_RST = 24'd32000;
   localparam logic [RATE_W-1:0] MAIN_RATE_RST   = 24'd32000;
   localparam logic [TIME_W-1:0] WARMUP_MS_RST   = 32'd30000;
   localparam logic [TIME_W-1:0] BUDGET_MS_RST   = 32'd1000;

   localparam logic [WAIT_W-1:0] WAIT_SAT = 16'hFFFF;

   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [LEN_W-1:0]  length;
      logic [TIME_W-1:0] due;
   } entry_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [TAG_W-1:0]  tag;
      logic [LEN_W-1:0]  length;
      logic [TIME_W-1:0] due;
      logic [TIME_W-1:0] added;
      logic              over;
      logic [WAIT_W-1:0] wait_ms;
      logic              last;
   } result_type;

endpackage

[hdl/paced_delay_fifo_core.sv]
// paced_delay_fifo_core: rate-paced delay queue with a bit-serial divider; uses pdfifo_pkg.
// Arrival: result passes S_SETUP, S_DIV, S_SUM, S_ADD and S_FIN (a drop when full leaves from
//   S_SETUP); the restoring divider retires one quotient bit per cycle; next item only in S_IDLE.
// Tick: released items pass S_TICK_RD and S_TICK_CHK (registered read port); a status item
//   leaves S_TICK_RD if empty, else S_TICK_CHK. Results wait in one output register.
// Reset (synchronous, active high) empties the queue and restores the register defaults.
module paced_delay_fifo_core #(
   parameter int QUEUE_DEPTH = pdfifo_pkg::QUEUE_DEPTH_DEF,
   parameter int FRAC_BITS   = pdfifo_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // arrival / tick items
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_op,
   input  logic [pdfifo_pkg::TIME_W-1:0]      req_now_ms,
   input  logic [pdfifo_pkg::TAG_W-1:0]       req_packet_tag,
   input  logic [pdfifo_pkg::LEN_W-1:0]       req_packet_length,
   // result items
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [pdfifo_pkg::KIND_W-1:0]      rsp_kind,
   output logic [pdfifo_pkg::TAG_W-1:0]       rsp_out_tag,
   output logic [pdfifo_pkg::LEN_W-1:0]       rsp_out_length,
   output logic [pdfifo_pkg::TIME_W-1:0]      rsp_due_ms,
   output logic [pdfifo_pkg::TIME_W-1:0]      rsp_added_delay_ms,
   output logic                               rsp_over_budget,
   output logic [pdfifo_pkg::WAIT_W-1:0]      rsp_wait_ms,
   output logic                               rsp_last,
   // register writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pdfifo_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pdfifo_pkg::CSR_DAT_W-1:0]   csr_wdata
);

   // dividend is length << (8 + FRAC_BITS); quotient has as many bits
   localparam int ZERO_FILL = pdfifo_pkg::Q8_SHIFT + FRAC_BITS;
   localparam int DW        = pdfifo_pkg::LEN_W + ZERO_FILL;
   localparam int DLY_W     = DW + 1 - FRAC_BITS;        // integer part of carry + quotient
   localparam int DCNT_W    = $clog2(DW + 1);
   localparam int IDX_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int RW        = pdfifo_pkg::RATE_W;
   localparam int TW        = pdfifo_pkg::TIME_W;
   localparam int WW        = pdfifo_pkg::WAIT_W;

   // one-hot sequencer
   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_SETUP    = 8'b0000_0010,   // pick rate, load divider, read tail entry
      S_DIV      = 8'b0000_0100,   // one quotient bit per cycle
      S_SUM      = 8'b0000_1000,   // add fraction carry, pick base time
      S_ADD      = 8'b0001_0000,   // base + delay, saturate
      S_FIN      = 8'b0010_0000,   // push entry, emit accepted item
      S_TICK_RD  = 8'b0100_0000,   // read head entry
      S_TICK_CHK = 8'b1000_0000    // release head or report wait
   } state_type;

   state_type state_ff, state_in;

   // latched request
   logic [TW-1:0]                    now_ff;
   logic [pdfifo_pkg::TAG_W-1:0]     tag_ff;
   logic [pdfifo_pkg::LEN_W-1:0]     len_ff;

   // configuration
   logic [RW-1:0] warmup_rate_ff, main_rate_ff;
   logic [TW-1:0] warmup_ms_ff, budget_ms_ff;

   // pacing state
   logic                 started_ff, started_in;
   logic [TW-1:0]        start_ms_ff, start_ms_in;
   logic [FRAC_BITS-1:0] carry_ff, carry_in;

   // queue pointers
   logic [IDX_W-1:0] head_ff, head_in, tail_ff, tail_in, tail_prev;
   logic [CNT_W-1:0] count_ff, count_in;

   // divider and arithmetic datapath
   logic [RW-1:0]     rate_ff, rate_in;
   logic [RW-1:0]     rem_ff, rem_in;
   logic [DW-1:0]     dvd_ff, dvd_in;      // dividend shifts out, quotient shifts in
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic [DLY_W-1:0]  dly_ff, dly_in;
   logic [TW-1:0]     base_ff, base_in;
   logic [TW-1:0]     due_ff, due_in;

   // combinational helpers
   logic [RW:0]   rem_shift, rem_diff;
   logic          rem_ge;
   logic [DW:0]   total;
   logic [TW:0]   due_sum;
   logic [TW-1:0] elapsed, added, head_gap;
   logic [RW-1:0] rate_pick;

   // queue memory
   pdfifo_pkg::entry_type fifo_mem [QUEUE_DEPTH];
   pdfifo_pkg::entry_type rd_data_ff, wr_entry;
   logic                  mem_we, rd_en;
   logic [IDX_W-1:0]      rd_addr;

   // output register
   pdfifo_pkg::result_type rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_load, out_free;

   logic req_accept, full, empty;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);

   assign tail_prev = (tail_ff == '0) ? IDX_W'(QUEUE_DEPTH - 1) : tail_ff - 1'b1;

   // shared subtract/compare of the restoring divider
   assign rem_shift = {rem_ff, dvd_ff[DW-1]};
   assign rem_diff  = rem_shift - {1'b0, rate_ff};
   assign rem_ge    = (rem_shift >= {1'b0, rate_ff});

   assign total    = (DW + 1)'(carry_ff) + {1'b0, dvd_ff};
   assign due_sum  = {1'b0, base_ff} + (TW + 1)'(dly_ff);
   assign elapsed  = (now_ff >= start_ms_ff) ? now_ff - start_ms_ff : '0;
   assign added    = due_ff - now_ff;
   assign head_gap = rd_data_ff.due - now_ff;

   // warm-up rate while elapsed <= warmup_ms; a zero rate counts as one
   always_comb begin
      rate_pick = (elapsed <= warmup_ms_ff) ? warmup_rate_ff : main_rate_ff;
      if (rate_pick == '0) begin
         rate_pick = RW'(1);
      end
   end

   assign wr_entry.tag    = tag_ff;
   assign wr_entry.length = len_ff;
   assign wr_entry.due    = due_ff;

   // sequencer
   always_comb begin
      state_in    = state_ff;
      started_in  = started_ff;
      start_ms_in = start_ms_ff;
      carry_in    = carry_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      rate_in     = rate_ff;
      rem_in      = rem_ff;
      dvd_in      = dvd_ff;
      dcnt_in     = dcnt_ff;
      dly_in      = dly_ff;
      base_in     = base_ff;
      due_in      = due_ff;
      mem_we      = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = tail_prev;
      rsp_load    = 1'b0;
      rsp_in      = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_op == pdfifo_pkg::OP_ARRIVAL) begin
                  // first arrival after reset opens the warm-up window
                  if (!started_ff) begin
                     started_in  = 1'b1;
                     start_ms_in = req_now_ms;
                  end
                  state_in = S_SETUP;
               end else begin
                  state_in = S_TICK_RD;
               end
            end
         end

         S_SETUP: begin
            rd_en   = 1'b1;
            rate_in = rate_pick;
            rem_in  = '0;
            dvd_in  = {len_ff, {ZERO_FILL{1'b0}}};
            dcnt_in = DCNT_W'(DW);
            if (full) begin
               // dropped: carry untouched, delay fields zero
               if (out_free) begin
                  rsp_load      = 1'b1;
                  rsp_in.kind   = pdfifo_pkg::KIND_DROPPED;
                  rsp_in.tag    = tag_ff;
                  rsp_in.length = len_ff;
                  rsp_in.last   = 1'b1;
                  state_in      = S_IDLE;
               end
            end else begin
               state_in = S_DIV;
            end
         end

         S_DIV: begin
            rem_in  = rem_ge ? rem_diff[RW-1:0] : rem_shift[RW-1:0];
            dvd_in  = {dvd_ff[DW-2:0], rem_ge};
            dcnt_in = dcnt_ff - 1'b1;
            if (dcnt_ff == DCNT_W'(1)) begin
               state_in = S_SUM;
            end
         end

         S_SUM: begin
            dly_in   = total[DW:FRAC_BITS];
            carry_in = total[FRAC_BITS-1:0];
            // newest queued due time when later than now
            base_in  = (!empty && (rd_data_ff.due > now_ff)) ? rd_data_ff.due : now_ff;
            state_in = S_ADD;
         end

         S_ADD: begin
            due_in   = due_sum[TW] ? {TW{1'b1}} : due_sum[TW-1:0];
            state_in = S_FIN;
         end

         S_FIN: begin
            if (out_free) begin
               mem_we        = 1'b1;
               tail_in       = (tail_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
               count_in      = count_ff + 1'b1;
               rsp_load      = 1'b1;
               rsp_in.kind   = pdfifo_pkg::KIND_ACCEPTED;
               rsp_in.tag    = tag_ff;
               rsp_in.length = len_ff;
               rsp_in.due    = due_ff;
               rsp_in.added  = added;
               rsp_in.over   = (added > budget_ms_ff);
               rsp_in.last   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         S_TICK_RD: begin
            if (empty) begin
               if (out_free) begin
                  rsp_load       = 1'b1;
                  rsp_in.kind    = pdfifo_pkg::KIND_STATUS;
                  rsp_in.wait_ms = pdfifo_pkg::WAIT_SAT;
                  rsp_in.last    = 1'b1;
                  state_in       = S_IDLE;
               end
            end else begin
               rd_en    = 1'b1;
               rd_addr  = head_ff;
               state_in = S_TICK_CHK;
            end
         end

         S_TICK_CHK: begin
            if (out_free) begin
               rsp_load = 1'b1;
               if (rd_data_ff.due <= now_ff) begin
                  rsp_in.kind   = pdfifo_pkg::KIND_RELEASED;
                  rsp_in.tag    = rd_data_ff.tag;
                  rsp_in.length = rd_data_ff.length;
                  rsp_in.due    = rd_data_ff.due;
                  head_in  = (head_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
                  count_in = count_ff - 1'b1;
                  state_in = S_TICK_RD;
               end else begin
                  // head still pending: report its wait, saturated
                  rsp_in.kind    = pdfifo_pkg::KIND_STATUS;
                  rsp_in.wait_ms = (|head_gap[TW-1:WW]) ? pdfifo_pkg::WAIT_SAT
                                                        : head_gap[WW-1:0];
                  rsp_in.last    = 1'b1;
                  state_in       = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         started_ff     <= 1'b0;
         start_ms_ff    <= '0;
         carry_ff       <= '0;
         head_ff        <= '0;
         tail_ff        <= '0;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         warmup_rate_ff <= pdfifo_pkg::WARMUP_RATE_RST;
         main_rate_ff   <= pdfifo_pkg::MAIN_RATE_RST;
         warmup_ms_ff   <= pdfifo_pkg::WARMUP_MS_RST;
         budget_ms_ff   <= pdfifo_pkg::BUDGET_MS_RST;
      end else begin
         state_ff    <= state_in;
         started_ff  <= started_in;
         start_ms_ff <= start_ms_in;
         carry_ff    <= carry_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               pdfifo_pkg::CSR_WARMUP_RATE: warmup_rate_ff <= csr_wdata[RW-1:0];
               pdfifo_pkg::CSR_MAIN_RATE:   main_rate_ff   <= csr_wdata[RW-1:0];
               pdfifo_pkg::CSR_WARMUP_MS:   warmup_ms_ff   <= csr_wdata[TW-1:0];
               pdfifo_pkg::CSR_BUDGET_MS:   budget_ms_ff   <= csr_wdata[TW-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         now_ff <= req_now_ms;
         tag_ff <= req_packet_tag;
         len_ff <= req_packet_length;
      end
      rate_ff <= rate_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      dcnt_ff <= dcnt_in;
      dly_ff  <= dly_in;
      base_ff <= base_in;
      due_ff  <= due_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   // queue memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         fifo_mem[tail_ff] <= wr_entry;
      end
      if (rd_en) begin
         rd_data_ff <= fifo_mem[rd_addr];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_ff.kind;
   assign rsp_out_tag        = rsp_ff.tag;
   assign rsp_out_length     = rsp_ff.length;
   assign rsp_due_ms         = rsp_ff.due;
   assign rsp_added_delay_ms = rsp_ff.added;
   assign rsp_over_budget    = rsp_ff.over;
   assign rsp_wait_ms        = rsp_ff.wait_ms;
   assign rsp_last           = rsp_ff.last;

endmodule
